@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define NMWS_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition at one edge that requires a consequence at the next edge.
`define NMWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/nmws_pkg.sv @@
// Shared types, constants and a helper function of the mismatch window search unit.
package nmws_pkg;

    localparam int MAX_PATTERN_LEN = 32;
    localparam int PATTERN_SLOTS   = 2;
    localparam int NIBBLE_BITS     = 4;
    localparam int LEN_W           = 6;
    localparam int NIB_IDX_W       = $clog2(MAX_PATTERN_LEN);
    localparam int POS_W           = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int USE_W           = 2;
    localparam int GROUP_NIBS      = 4;
    localparam int GROUPS          = MAX_PATTERN_LEN / GROUP_NIBS;
    localparam int PSUM_W          = $clog2(GROUP_NIBS * NIBBLE_BITS + 1);
    localparam int MATCH_W         = $clog2(MAX_PATTERN_LEN * NIBBLE_BITS + 1);
    localparam int POP_W           = $clog2(NIBBLE_BITS + 1);
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MISMATCH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERNS_USED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN0_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN0_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN1_LOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN1_HIGH  = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0] RESET_PATTERN_LENGTH = 6'd20;
    localparam logic [LEN_W-1:0] RESET_MAX_MISMATCH   = 6'd4;
    localparam logic [USE_W-1:0] RESET_PATTERNS_USED  = 2'd1;

    typedef logic [MAX_PATTERN_LEN-1:0][NIBBLE_BITS-1:0] nib_vec_t;

    // One input transaction.
    typedef struct packed {
        logic [NIBBLE_BITS-1:0] nucleotide;
        logic                   new_sequence;
    } in_t;

    // One result transaction.
    typedef struct packed {
        logic [POS_W-1:0] location;
        logic             pattern_index;
        logic [LEN_W-1:0] mismatches;
        logic             last;
    } out_t;

    // Effective configuration as seen by the datapath.
    typedef struct packed {
        logic [LEN_W-1:0]                  len;
        logic [LEN_W-1:0]                  limit;
        logic [PATTERN_SLOTS-1:0]          slot_en;
        logic [PATTERN_SLOTS-1:0][MAX_PATTERN_LEN-1:0][NIBBLE_BITS-1:0] pattern;
    } cfg_t;

    // A full window, aligned so that nibble k faces pattern nibble k.
    typedef struct packed {
        logic [POS_W-1:0] location;
        nib_vec_t         window;
    } entry_t;

    // Number of set bits in one nucleotide code.
    function automatic logic [POP_W-1:0] pop4(input logic [NIBBLE_BITS-1:0] v);
        pop4 = POP_W'(v[0]) + POP_W'(v[1]) + POP_W'(v[2]) + POP_W'(v[3]);
    endfunction

endpackage

@@ rtl/core/nucleotide_mismatch_window_search_unit.sv @@
// Top level of the nucleotide mismatch window search unit.
//
// Input channel: one nucleotide code per transaction (in_valid / in_stall);
// new_sequence clears the window and the position before the code is taken.
// Once the window holds pattern_length codes, each pattern slot in use is
// compared and every slot within the mismatch limit gives one result
// transaction on the output channel (out_valid / out_stall), slot 0 first,
// with last set on the final result of that input.
// Registers: queue, stage one, current result, output. Throughput: one input
// per cycle unless in_stall is high; the output register sends one result per
// cycle unless out_stall is high, so an input that hits both slots holds the
// result side longer. A four-entry queue between the window front end and the
// compare back end absorbs this and output stalls; in_stall rises when full.
// While the receiver stalls, the current result stays unchanged on out_data.
// Reset clears the window, position and queue and loads the register
// defaults: length 20, limit 4, one slot, all-zero patterns.
// Configuration is written through cfg_wr_en / cfg_index / cfg_data while
// the block is idle; an index past the last register is ignored.
module nucleotide_mismatch_window_search_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  nmws_pkg::in_t                         in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output nmws_pkg::out_t                        out_data,
    input  logic                                  cfg_wr_en,
    input  logic [nmws_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nmws_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import nmws_pkg::*;

    logic [LEN_W-1:0]                           pattern_length_reg;
    logic [LEN_W-1:0]                           max_mismatch_reg;
    logic [USE_W-1:0]                           patterns_used_reg;
    logic [PATTERN_SLOTS-1:0][CFG_DATA_W-1:0]   pat_lo_reg;
    logic [PATTERN_SLOTS-1:0][CFG_DATA_W-1:0]   pat_hi_reg;
    cfg_t                                       cfg;
    logic                                       accept;
    logic                                       push;
    entry_t                                     push_data;
    logic                                       q_full;
    logic                                       q_valid;
    entry_t                                     q_head;
    logic                                       q_pop;

    // Effective configuration: length clamped to 1..32, slot count to 0..2.
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            cfg.len = LEN_W'(1);
        end
        else if (pattern_length_reg > LEN_W'(MAX_PATTERN_LEN))
        begin
            cfg.len = LEN_W'(MAX_PATTERN_LEN);
        end
        else
        begin
            cfg.len = pattern_length_reg;
        end
        cfg.limit   = max_mismatch_reg;
        cfg.slot_en = {patterns_used_reg[1], |patterns_used_reg};
        for (int s = 0; s < PATTERN_SLOTS; s++)
        begin
            cfg.pattern[s] = {pat_hi_reg[s], pat_lo_reg[s]};
        end
    end

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= RESET_PATTERN_LENGTH;
            max_mismatch_reg   <= RESET_MAX_MISMATCH;
            patterns_used_reg  <= RESET_PATTERNS_USED;
            pat_lo_reg         <= '0;
            pat_hi_reg         <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                REG_MAX_MISMATCH:   max_mismatch_reg   <= cfg_data[LEN_W-1:0];
                REG_PATTERNS_USED:  patterns_used_reg  <= cfg_data[USE_W-1:0];
                REG_PATTERN0_LOW:   pat_lo_reg[0]      <= cfg_data;
                REG_PATTERN0_HIGH:  pat_hi_reg[0]      <= cfg_data;
                REG_PATTERN1_LOW:   pat_lo_reg[1]      <= cfg_data;
                REG_PATTERN1_HIGH:  pat_hi_reg[1]      <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Input handshake.
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    nmws_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_data   (in_data),
        .cfg       (cfg),
        .push      (push),
        .push_data (push_data)
    );

    nmws_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    nmws_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .cfg       (cfg),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ rtl/core/nmws_front.sv @@
// Front end: sliding window, position tracking and window alignment.
module nmws_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  nmws_pkg::in_t   in_data,
    input  nmws_pkg::cfg_t  cfg,
    output logic            push,
    output nmws_pkg::entry_t push_data
);
    import nmws_pkg::*;

    nib_vec_t              window_reg;
    nib_vec_t              window_next;
    nib_vec_t              win_base;
    logic [POS_W-1:0]      position_reg;
    logic [POS_W-1:0]      position_next;
    logic [POS_W-1:0]      pos_base;
    logic [LEN_W-1:0]      fill_reg;
    logic [LEN_W-1:0]      fill_next;
    logic [LEN_W-1:0]      fill_base;
    logic [MAX_PATTERN_LEN-1:0][LEN_W-1:0] align_idx;

    // A new sequence clears the window before the nucleotide is shifted in.
    always_comb
    begin
        win_base      = in_data.new_sequence ? '0 : window_reg;
        pos_base      = in_data.new_sequence ? '0 : position_reg;
        fill_base     = in_data.new_sequence ? '0 : fill_reg;
        window_next   = {win_base[MAX_PATTERN_LEN-2:0], in_data.nucleotide};
        position_next = pos_base + 1'b1;
        if (fill_base < LEN_W'(MAX_PATTERN_LEN))
        begin
            fill_next = fill_base + 1'b1;
        end
        else
        begin
            fill_next = fill_base;
        end
    end

    // Align the window so that its oldest nucleotide faces pattern nibble 0.
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN_LEN; k++)
        begin
            align_idx[k] = cfg.len - LEN_W'(k) - 1'b1;
            if (LEN_W'(k) < cfg.len)
            begin
                push_data.window[k] = window_next[align_idx[k][NIB_IDX_W-1:0]];
            end
            else
            begin
                push_data.window[k] = '0;
            end
        end
        push_data.location = position_next - POS_W'(cfg.len);
        push = accept && (fill_next >= cfg.len);
    end

    // Window state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            position_reg <= '0;
            fill_reg     <= '0;
        end
        else if (accept)
        begin
            window_reg   <= window_next;
            position_reg <= position_next;
            fill_reg     <= fill_next;
        end
    end

endmodule

@@ rtl/core/nmws_queue.sv @@
// Short queue of aligned windows between the front end and the back end.
module nmws_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  nmws_pkg::entry_t push_data,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output nmws_pkg::entry_t head_data
);
    import nmws_pkg::*;

    entry_t              q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = q_mem_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/nmws_back.sv @@
// Back end: popcount compare against the patterns and result sequencing.
module nmws_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  nmws_pkg::entry_t q_head,
    input  nmws_pkg::cfg_t   cfg,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output nmws_pkg::out_t   out_data
);
    import nmws_pkg::*;

    logic [PATTERN_SLOTS-1:0][GROUPS-1:0][PSUM_W-1:0] psum_new;
    logic [PATTERN_SLOTS-1:0][GROUPS-1:0][PSUM_W-1:0] s1_psum_reg;
    logic                                    s1_valid_reg;
    logic [POS_W-1:0]                        s1_loc_reg;
    logic [PATTERN_SLOTS-1:0][MATCH_W-1:0]   match_sum;
    logic [PATTERN_SLOTS-1:0][LEN_W-1:0]     mm;
    logic [PATTERN_SLOTS-1:0]                hit;

    logic [PATTERN_SLOTS-1:0]                cur_mask_reg;
    logic [PATTERN_SLOTS-1:0]                cur_mask_next;
    logic [PATTERN_SLOTS-1:0]                mask_after;
    logic [PATTERN_SLOTS-1:0]                sel_bit;
    logic [POS_W-1:0]                        cur_loc_reg;
    logic [PATTERN_SLOTS-1:0][LEN_W-1:0]     cur_mm_reg;
    logic                                    sel;
    logic                                    emit;
    logic                                    out_free;
    logic                                    cur_free;
    logic                                    s1_leave;
    logic                                    s1_load;
    logic                                    cur_load;
    logic                                    out_valid_reg;
    out_t                                    out_data_reg;

    // Stage one: per-group popcounts of window AND pattern.
    always_comb
    begin
        for (int s = 0; s < PATTERN_SLOTS; s++)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                psum_new[s][g] = '0;
                for (int n = 0; n < GROUP_NIBS; n++)
                begin
                    psum_new[s][g] = psum_new[s][g] + PSUM_W'(pop4(
                        q_head.window[g*GROUP_NIBS+n] & cfg.pattern[s][g*GROUP_NIBS+n]));
                end
            end
        end
    end

    // Stage two: total matches, saturated mismatch count and hit test.
    always_comb
    begin
        for (int s = 0; s < PATTERN_SLOTS; s++)
        begin
            match_sum[s] = '0;
            for (int g = 0; g < GROUPS; g++)
            begin
                match_sum[s] = match_sum[s] + MATCH_W'(s1_psum_reg[s][g]);
            end
            if (match_sum[s] >= MATCH_W'(cfg.len))
            begin
                mm[s] = '0;
            end
            else
            begin
                mm[s] = cfg.len - match_sum[s][LEN_W-1:0];
            end
            hit[s] = cfg.slot_en[s] && (mm[s] <= cfg.limit);
        end
    end

    // Result sequencing: one hit per cycle while the output is not stalled, lowest slot first.
    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        emit     = (cur_mask_reg != '0) && out_free;
        sel      = !cur_mask_reg[0];
        sel_bit  = sel ? 2'b10 : 2'b01;
        mask_after = emit ? (cur_mask_reg & ~sel_bit) : cur_mask_reg;
        cur_free = (mask_after == '0);
        s1_leave = s1_valid_reg && ((hit == '0) || cur_free);
        cur_load = s1_leave && (hit != '0);
        s1_load  = q_valid && (!s1_valid_reg || s1_leave);
        cur_mask_next = cur_load ? hit : mask_after;
    end

    assign q_pop     = s1_load;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_psum_reg <= psum_new;
            s1_loc_reg  <= q_head.location;
        end
        if (cur_load)
        begin
            cur_loc_reg <= s1_loc_reg;
            cur_mm_reg  <= mm;
        end
        if (emit)
        begin
            out_data_reg.location      <= cur_loc_reg;
            out_data_reg.pattern_index <= sel;
            out_data_reg.mismatches    <= cur_mm_reg[sel];
            out_data_reg.last          <= ((cur_mask_reg & ~sel_bit) == '0);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            cur_mask_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_leave)
            begin
                s1_valid_reg <= 1'b0;
            end
            cur_mask_reg <= cur_mask_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/nmws_checker.sv @@
// Port-level checker for the mismatch window search unit and its bind.
`include "assert_macros.svh"

module nmws_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           out_valid,
    input  logic           out_stall,
    input  nmws_pkg::out_t out_data
);
    import nmws_pkg::*;

    // A stalled result must stay in place.
    `NMWS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    // A result that is not last is slot 0 and is followed at once by slot 1 of the same window.
    `NMWS_ASSERT_NEXT(a_pair_follow, clk, rst_n, out_valid && !out_stall && !out_data.last, out_valid && out_data.pattern_index == 1'b1 && out_data.last && out_data.location == $past(out_data.location), "second hit of a window missing or misplaced")

    // Mismatch counts never exceed the longest pattern, and slot 1 always closes its group.
    `NMWS_ASSERT_ALWAYS(a_out_range, clk, rst_n, !out_valid || (out_data.mismatches <= LEN_W'(MAX_PATTERN_LEN) && (out_data.last || out_data.pattern_index == 1'b0)), "result fields out of range")

endmodule

bind nucleotide_mismatch_window_search_unit nmws_checker u_nmws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the nucleotide mismatch window search unit.
`timescale 1ns / 100ps

module testbench;

    import nmws_pkg::*;

    // Index past the last register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int SETTLE_CYCLES = 12;
    localparam int STREAM_ITEMS  = 800;

    // Scoreboard: tracks window state and configuration, predicts hits.
    class hit_scoreboard;
        out_t                   pending_hits[$];
        int                     error_count;
        logic [LEN_W-1:0]       length_reg;
        logic [LEN_W-1:0]       limit_reg;
        logic [USE_W-1:0]       slots_reg;
        logic [CFG_DATA_W-1:0]  low_reg[PATTERN_SLOTS];
        logic [CFG_DATA_W-1:0]  high_reg[PATTERN_SLOTS];
        logic [NIBBLE_BITS-1:0] window[MAX_PATTERN_LEN];
        logic [POS_W-1:0]       position;
        int                     fill_count;

        function new();
            error_count = 0;
            length_reg  = RESET_PATTERN_LENGTH;
            limit_reg   = RESET_MAX_MISMATCH;
            slots_reg   = RESET_PATTERNS_USED;
            foreach (low_reg[s])
            begin
                low_reg[s]  = '0;
                high_reg[s] = '0;
            end
            foreach (window[i])
                window[i] = '0;
            position   = '0;
            fill_count = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_PATTERN_LENGTH: length_reg = value[LEN_W-1:0];
                REG_MAX_MISMATCH:   limit_reg = value[LEN_W-1:0];
                REG_PATTERNS_USED:  slots_reg = value[USE_W-1:0];
                REG_PATTERN0_LOW:   low_reg[0] = value;
                REG_PATTERN0_HIGH:  high_reg[0] = value;
                REG_PATTERN1_LOW:   low_reg[1] = value;
                REG_PATTERN1_HIGH:  high_reg[1] = value;
                default: ;
            endcase
        endfunction

        // Shift in one nucleotide and queue the hits it produces.
        function void predict_hits(in_t item);
            int                     len;
            int                     used;
            int                     match_total;
            int                     last_slot;
            int                     miss[PATTERN_SLOTS];
            bit                     hit[PATTERN_SLOTS];
            logic [NIBBLE_BITS-1:0] nib;
            out_t                   result;

            if (item.new_sequence)
            begin
                foreach (window[i])
                    window[i] = '0;
                position   = '0;
                fill_count = 0;
            end
            for (int i = MAX_PATTERN_LEN - 1; i > 0; i--)
                window[i] = window[i-1];
            window[0] = item.nucleotide;
            if (fill_count < MAX_PATTERN_LEN)
                fill_count++;
            position = position + 1'b1;

            // Out-of-range settings clamp to the nearest legal value.
            len = (length_reg == 0) ? 1 :
                  (length_reg > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(length_reg);
            used = (slots_reg > PATTERN_SLOTS) ? PATTERN_SLOTS : int'(slots_reg);
            if (fill_count < len)
                return;

            // The oldest nucleotide of the window faces pattern nibble 0.
            last_slot = -1;
            for (int s = 0; s < PATTERN_SLOTS; s++)
            begin
                hit[s] = 1'b0;
                miss[s] = 0;
                if (s < used)
                begin
                    match_total = 0;
                    for (int k = 0; k < len; k++)
                    begin
                        nib = (k < MAX_PATTERN_LEN / 2) ?
                              low_reg[s][NIBBLE_BITS*k +: NIBBLE_BITS] :
                              high_reg[s][NIBBLE_BITS*(k - MAX_PATTERN_LEN/2) +: NIBBLE_BITS];
                        match_total += $countones(window[len-1-k] & nib);
                    end
                    miss[s] = (match_total >= len) ? 0 : len - match_total;
                    if (miss[s] <= int'(limit_reg))
                    begin
                        hit[s] = 1'b1;
                        last_slot = s;
                    end
                end
            end
            for (int s = 0; s < PATTERN_SLOTS; s++)
            begin
                if (hit[s])
                begin
                    result.location      = position - POS_W'(len);
                    result.pattern_index = s[0];
                    result.mismatches    = miss[s][LEN_W-1:0];
                    result.last          = (s == last_slot);
                    pending_hits.push_back(result);
                end
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            error_count++;
        endtask

        // Compare one received hit with the oldest predicted one.
        task check_hit(out_t got);
            out_t want;
            if (pending_hits.size() == 0)
            begin
                report($sformatf("unexpected hit at location %0d slot %0d",
                                 got.location, got.pattern_index));
                return;
            end
            want = pending_hits.pop_front();
            if (got.location !== want.location)
                report($sformatf("location %0d, expected %0d", got.location, want.location));
            if (got.pattern_index !== want.pattern_index)
                report($sformatf("pattern_index %0d, expected %0d at location %0d",
                                 got.pattern_index, want.pattern_index, want.location));
            if (got.mismatches !== want.mismatches)
                report($sformatf("mismatches %0d, expected %0d at location %0d",
                                 got.mismatches, want.mismatches, want.location));
            if (got.last !== want.last)
                report($sformatf("last %0b, expected %0b at location %0d",
                                 got.last, want.last, want.location));
        endtask

        task check_drained();
            if (pending_hits.size() != 0)
                report($sformatf("%0d predicted hits never arrived", pending_hits.size()));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_t                  out_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hit_scoreboard sb = new();

    // Stimulus view of the current settings.
    int           cur_len = int'(RESET_PATTERN_LENGTH);
    logic [127:0] cur_pat[PATTERN_SLOTS] = '{default: '0};
    bit           tx_steady = 1'b0;
    bit           rx_steady = 1'b0;

    nucleotide_mismatch_window_search_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Send one nucleotide transaction; called and returning at a falling edge.
    task automatic send_item(logic [NIBBLE_BITS-1:0] nuc, logic new_seq);
        int   gap;
        in_t  item;
        item.nucleotide   = nuc;
        item.new_sequence = new_seq;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        sb.predict_hits(item);
        @(negedge clk);
    endtask

    // Wait for the block to go idle, then write every register.
    task automatic load_config(logic [LEN_W-1:0] len_v, logic [LEN_W-1:0] lim_v,
                               logic [USE_W-1:0] used_v, logic [127:0] pat0,
                               logic [127:0] pat1);
        logic [CFG_DATA_W-1:0] values[8];
        values[REG_PATTERN_LENGTH] = CFG_DATA_W'(len_v);
        values[REG_MAX_MISMATCH]   = CFG_DATA_W'(lim_v);
        values[REG_PATTERNS_USED]  = CFG_DATA_W'(used_v);
        values[REG_PATTERN0_LOW]   = pat0[63:0];
        values[REG_PATTERN0_HIGH]  = pat0[127:64];
        values[REG_PATTERN1_LOW]   = pat1[63:0];
        values[REG_PATTERN1_HIGH]  = pat1[127:64];
        values[REG_SPARE]          = {$urandom, $urandom};

        in_valid <= 1'b0;
        while (sb.pending_hits.size() != 0)
            @(negedge clk);
        // Items without hits may still be in flight.
        repeat (SETTLE_CYCLES) @(negedge clk);
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= values[i];
            @(posedge clk);
            sb.write_register(CFG_IDX_W'(i), values[i]);
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;

        cur_len = (len_v == 0) ? 1 : (len_v > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(len_v);
        cur_pat[0] = pat0;
        cur_pat[1] = pat1;
    endtask

    // Mostly mutated copies of the loaded patterns, with noise between them.
    task automatic run_stream(int count);
        int                     k;
        int                     slot;
        logic [NIBBLE_BITS-1:0] nuc;
        logic                   new_seq;
        k = cur_len;
        slot = 0;
        repeat (count)
        begin
            new_seq = ($urandom_range(0, 39) == 0);
            if (new_seq)
                k = cur_len;
            if (k >= cur_len && $urandom_range(0, 2) == 0)
            begin
                k = 0;
                slot = $urandom_range(0, 1);
            end
            if (k < cur_len)
            begin
                nuc = cur_pat[slot][NIBBLE_BITS*k +: NIBBLE_BITS];
                if ($urandom_range(0, 7) == 0)
                    nuc = NIBBLE_BITS'($urandom_range(0, 15));
                k++;
            end
            else if ($urandom_range(0, 1) == 0)
                nuc = 4'b0001 << $urandom_range(0, 3);
            else
                nuc = NIBBLE_BITS'($urandom_range(0, 15));
            send_item(nuc, new_seq);
        end
    endtask

    // Pick a random setting, load it and stream random content.
    task automatic run_random_phase(int count);
        logic [LEN_W-1:0] len_v;
        logic [LEN_W-1:0] lim_v;
        logic [USE_W-1:0] used_v;
        logic [127:0]     pat[PATTERN_SLOTS];
        int               eff;
        int               pick;

        pick = $urandom_range(0, 9);
        if (pick == 0)
            len_v = LEN_W'(1);
        else if (pick == 1)
            len_v = LEN_W'(MAX_PATTERN_LEN);
        else if (pick == 2)
            len_v = $urandom_range(0, 1) ? '0 :
                    LEN_W'($urandom_range(MAX_PATTERN_LEN + 1, 63));
        else
            len_v = LEN_W'($urandom_range(2, MAX_PATTERN_LEN - 1));
        eff = (len_v == 0) ? 1 : (len_v > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(len_v);

        pick = $urandom_range(0, 9);
        if (pick == 0)
            lim_v = '0;
        else if (pick == 1)
            lim_v = '1;
        else if (pick == 2)
            lim_v = LEN_W'($urandom_range(0, 63));
        else
            lim_v = LEN_W'($urandom_range(0, eff / 3));

        pick = $urandom_range(0, 9);
        used_v = (pick == 0) ? 2'd0 : (pick == 1) ? 2'd3 : 2'($urandom_range(1, 2));

        // Patterns: raw random bits, all zero, all ones or one-hot bases.
        for (int s = 0; s < PATTERN_SLOTS; s++)
        begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                pat[s] = {$urandom, $urandom, $urandom, $urandom};
            else if (pick == 1)
                pat[s] = '0;
            else if (pick == 2)
                pat[s] = '1;
            else
                for (int k = 0; k < MAX_PATTERN_LEN; k++)
                    pat[s][NIBBLE_BITS*k +: NIBBLE_BITS] = 4'b0001 << $urandom_range(0, 3);
        end

        load_config(len_v, lim_v, used_v, pat[0], pat[1]);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        run_stream(count);
    endtask

    // Result side: random stall before each transaction, then accept it.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            hold = rx_steady ? 0 : $urandom_range(0, 6);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid === 1'b1 && !out_stall));
            sb.check_hit(out_data);
        end
    end

    // Main sequence: reset, directed checks, then random phases.
    initial
    begin
        int sent;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: the window never fills, so nothing is reported.
        send_item(4'h0, 1'b1);
        send_item(4'hF, 1'b0);

        // Single-nucleotide patterns with zero tolerance on both slots.
        load_config(6'd1, 6'd0, 2'd2, 128'hF, 128'h1);
        send_item(4'hF, 1'b1);
        send_item(4'h0, 1'b0);
        send_item(4'h1, 1'b0);
        send_item(4'h8, 1'b0);
        send_item(4'h7, 1'b0);

        // Zero length acts as one and three slots act as two.
        load_config(6'd0, 6'd63, 2'd3, '1, '0);
        send_item(4'hA, 1'b0);
        send_item(4'h5, 1'b0);

        // Length shortened mid-sequence: the window already holds more than three codes.
        load_config(6'd3, 6'd1, 2'd1, 128'h842, '1);
        send_item(4'h2, 1'b0);
        send_item(4'h4, 1'b0);
        send_item(4'h8, 1'b0);

        // No slot in use: no hits at all.
        load_config(6'd1, 6'd63, 2'd0, '1, '1);
        send_item(4'hF, 1'b0);
        send_item(4'h3, 1'b1);

        // Oversized length clamps to the full window; a zero pattern misses every nibble yet hits at the limit of 32.
        load_config(6'd63, 6'd32, 2'd2, '0, '1);
        run_stream(60);
        sent = 60;

        while (sent < STREAM_ITEMS)
        begin
            int count;
            count = $urandom_range(20, 80);
            run_random_phase(count);
            sent += count;
        end

        in_valid <= 1'b0;
        while (sb.pending_hits.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        sb.check_drained();
        if (sb.error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
